// ===== hdl/pds_pkg.sv =====
// shared types and constants for the periodic deadline scheduler
// no dependencies; used by pds_divrem and periodic_deadline_scheduler
`default_nettype none

package pds_pkg;

   // defaults for top-level parameters
   localparam int ENTRIES_DEF     = 16;
   localparam int PERIOD_BITS_DEF = 48;

   // fixed field widths
   localparam int TIME_W      = 63;
   localparam int PER_FIELD_W = 48;
   localparam int SLOT_W      = 4;
   localparam int SUM_W       = TIME_W + 3;

   // largest number of results caused by one alarm
   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   // stream payload widths
   localparam int REQ_DATA_W = 232;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;

   localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_ALARM  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_WRITE,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_EMIT,
      ST_FIRE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/pds_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module pds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pds_divrem.sv =====
// restoring remainder unit, one quotient bit per cycle
// depends on pds_pkg
`default_nettype none

module pds_divrem #(
   parameter int DIV_W = pds_pkg::PERIOD_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pds_pkg::TIME_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]          divisor,
   output logic                           busy,
   output logic                           done,
   output logic      [DIV_W-1:0]          rem
);

   localparam int STEP_W = $clog2(pds_pkg::TIME_W);

   logic [pds_pkg::TIME_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]           rem_ff, rem_in;
   logic [DIV_W-1:0]           dsr_ff, dsr_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_W:0]             trial;

   // one trial subtraction per step
   always_comb begin
      trial   = {rem_ff, dvd_ff[pds_pkg::TIME_W-1]};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[pds_pkg::TIME_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(pds_pkg::TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = rem_ff;

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder unit still busy after done");
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");
`endif

endmodule

`default_nettype wire

// ===== hdl/periodic_deadline_scheduler.sv =====
// top level of the periodic deadline scheduler: sequencer, table scan, valid bits
// depends on pds_pkg, pds_ram, pds_divrem
//
//  channel | direction | payload
//  req     | in        | tuser: command; tdata: slot, start_time, period_ns, offset_ns, now_time
//  rsp     | out       | tdata: out_slot, fired, status, next_deadline, deadline_valid; tlast
//
// one item at a time; req_tready is high only while idle
// add: the 63-step remainder unit, a table write, then one table scan (a full table goes straight to the scan)
// alarm: one table scan, then per fired entry the remainder unit, a table write and another table scan
// remove and clear: one table scan through the ram read port
// reset empties the table at once through per-slot valid bits; no clearing pass
// a result waits in the output register while rsp_tready is low, and the sequencer holds
`default_nettype none

module periodic_deadline_scheduler #(
   parameter int ENTRIES     = pds_pkg::ENTRIES_DEF,
   parameter int PERIOD_BITS = pds_pkg::PERIOD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // slot[3:0], start_time[66:4], period_ns[114:67], offset_ns[162:115],
   // now_time[225:163], zero fill[231:226]
   input  wire logic [pds_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command[1:0]
   input  wire logic [pds_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_slot[3:0], fired[4], status[6:5], next_deadline[69:7],
   // deadline_valid[70], zero fill[71]
   output logic      [pds_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int TW     = pds_pkg::TIME_W;
   localparam int SW     = pds_pkg::SUM_W;
   localparam int MEM_W  = PERIOD_BITS + TW;
   localparam int RW     = pds_pkg::RES_W;

   // request fields
   logic [pds_pkg::SLOT_W-1:0]      f_slot;
   logic [TW-1:0]                   f_start;
   logic [pds_pkg::PER_FIELD_W-1:0] f_period;
   logic [pds_pkg::PER_FIELD_W-1:0] f_offset;
   logic [TW-1:0]                   f_now;
   pds_pkg::cmd_type                f_cmd;

   assign f_slot   = req_tdata[3:0];
   assign f_start  = req_tdata[66:4];
   assign f_period = req_tdata[114:67];
   assign f_offset = req_tdata[162:115];
   assign f_now    = req_tdata[225:163];
   assign f_cmd    = pds_pkg::cmd_type'(req_tuser[1:0]);

   // state
   pds_pkg::state_type         state_ff, state_in;
   pds_pkg::cmd_type           cmd_ff;
   pds_pkg::status_type        status_ff;
   logic                       fired_ff;
   logic [pds_pkg::SLOT_W-1:0] slot_out_ff;
   logic [IDX_W-1:0]           tgt_ff;
   logic [TW-1:0]              now_ff;
   logic [PERIOD_BITS-1:0]     per_ff;
   logic [SW-1:0]              base_ff;
   logic                       neg_ff;
   logic [TW-1:0]              absd_ff;
   logic [ENTRIES-1:0]         valid_ff;
   logic [ENTRIES-1:0]         done_ff;
   logic [RW-1:0]              nres_ff;
   logic                       head_ff;

   // scan registers
   logic [CNT_W-1:0]           scan_cnt_ff;
   logic                       rd_pend_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic                       all_vld_ff;
   logic [TW-1:0]              all_d_ff;
   logic                       cand_vld_ff;
   logic [TW-1:0]              cand_d_ff;
   logic [PERIOD_BITS-1:0]     cand_p_ff;
   logic [IDX_W-1:0]           cand_idx_ff;

   // output register
   logic                            rsp_valid_ff;
   logic [pds_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic                            rsp_last_ff;

   // control
   logic accept, div_start, mem_we, scan_issue, emit_go, scan_end, last_now;

   // lowest free slot
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // remove lookup
   logic [IDX_W-1:0] rm_idx;
   logic             rm_hit;
   assign rm_idx = IDX_W'(f_slot);
   assign rm_hit = (32'(f_slot) < ENTRIES) && valid_ff[rm_idx];

   // normalized period, zero taken as one
   logic [63:0]            per_ext;
   logic [PERIOD_BITS-1:0] per_norm;
   always_comb begin
      per_ext  = {16'b0, f_period};
      per_norm = per_ext[PERIOD_BITS-1:0];
      if (per_norm == '0) begin
         per_norm = PERIOD_BITS'(1);
      end
   end

   // signed time difference and base for the remainder unit
   logic [TW:0]            diff;
   logic [TW:0]            diff_abs;
   logic [SW-1:0]          base_nx;
   logic [PERIOD_BITS-1:0] dsr_nx;
   always_comb begin
      if (state_ff == pds_pkg::ST_FIRE) begin
         diff    = {1'b0, now_ff} - {1'b0, cand_d_ff};
         base_nx = SW'(cand_d_ff) + SW'(cand_p_ff);
         dsr_nx  = cand_p_ff;
      end else begin
         diff    = {1'b0, f_now} - {1'b0, f_start};
         base_nx = SW'(f_start) + SW'(f_offset) + SW'(per_norm);
         dsr_nx  = per_norm;
      end
      diff_abs = diff[TW] ? (~diff + (TW+1)'(1)) : diff;
   end

   // remainder unit
   logic                   div_busy, div_done;
   logic [PERIOD_BITS-1:0] div_rem;

   pds_divrem #(.DIV_W(PERIOD_BITS)) u_divrem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_abs[TW-1:0]),
      .divisor  (dsr_nx),
      .busy     (div_busy),
      .done     (div_done),
      .rem      (div_rem)
   );

   // saturated new deadline
   logic [SW-1:0] mag, sum_pos, dif_neg;
   logic [TW-1:0] new_dl;
   always_comb begin
      mag     = SW'(absd_ff) - SW'(div_rem);
      sum_pos = base_ff + mag;
      dif_neg = base_ff - mag;
      if (!neg_ff) begin
         new_dl = (sum_pos > SW'(pds_pkg::MAX_TIME)) ? pds_pkg::MAX_TIME : sum_pos[TW-1:0];
      end else if (mag > base_ff) begin
         new_dl = '0;
      end else begin
         new_dl = (dif_neg > SW'(pds_pkg::MAX_TIME)) ? pds_pkg::MAX_TIME : dif_neg[TW-1:0];
      end
   end

   // table memory: period above deadline
   logic [MEM_W-1:0] rd_data;
   logic [TW-1:0]    rd_d;
   logic [PERIOD_BITS-1:0] rd_p;
   assign rd_d = rd_data[TW-1:0];
   assign rd_p = rd_data[MEM_W-1:TW];

   pds_ram #(.WIDTH(MEM_W), .DEPTH(ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (tgt_ff),
      .wr_data ({per_ff, new_dl}),
      .rd_en   (scan_issue),
      .rd_addr (scan_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign scan_end = (scan_cnt_ff == CNT_W'(ENTRIES)) && !rd_pend_ff;
   assign last_now = (cmd_ff != pds_pkg::CMD_ALARM) || head_ff || !cand_vld_ff ||
                     (nres_ff >= RW'(pds_pkg::MAX_RESULTS - 1)) || (cand_d_ff > now_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pds_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (f_cmd == pds_pkg::CMD_ADD && free_found) begin
                  state_in = pds_pkg::ST_DIV;
               end else begin
                  state_in = pds_pkg::ST_SCAN_INIT;
               end
            end
         end
         pds_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = pds_pkg::ST_WRITE;
            end
         end
         pds_pkg::ST_WRITE:     state_in = pds_pkg::ST_SCAN_INIT;
         pds_pkg::ST_SCAN_INIT: state_in = pds_pkg::ST_SCAN;
         pds_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (cmd_ff == pds_pkg::CMD_ALARM && head_ff && cand_vld_ff) begin
                  state_in = pds_pkg::ST_FIRE;
               end else begin
                  state_in = pds_pkg::ST_EMIT;
               end
            end
         end
         pds_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = last_now ? pds_pkg::ST_IDLE : pds_pkg::ST_FIRE;
            end
         end
         pds_pkg::ST_FIRE:      state_in = pds_pkg::ST_DIV;
         default:               state_in = pds_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      mem_we     = 1'b0;
      scan_issue = 1'b0;
      emit_go    = 1'b0;
      case (state_ff)
         pds_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_tvalid && f_cmd == pds_pkg::CMD_ADD && free_found;
         end
         pds_pkg::ST_WRITE: mem_we = 1'b1;
         pds_pkg::ST_SCAN:  scan_issue = scan_cnt_ff < CNT_W'(ENTRIES);
         pds_pkg::ST_EMIT:  emit_go = !rsp_valid_ff || rsp_tready;
         pds_pkg::ST_FIRE:  div_start = 1'b1;
         default: begin
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pds_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_pend_ff <= scan_issue;
         if (accept) begin
            case (f_cmd)
               pds_pkg::CMD_REMOVE: begin
                  if (rm_hit) begin
                     valid_ff[rm_idx] <= 1'b0;
                  end
               end
               pds_pkg::CMD_CLEAR: valid_ff <= '0;
               default: begin
               end
            endcase
         end
         if (mem_we) begin
            valid_ff[tgt_ff] <= 1'b1;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= f_cmd;
         now_ff      <= f_now;
         per_ff      <= per_norm;
         base_ff     <= base_nx;
         neg_ff      <= diff[TW];
         absd_ff     <= diff_abs[TW-1:0];
         fired_ff    <= 1'b0;
         tgt_ff      <= free_idx;
         done_ff     <= '0;
         nres_ff     <= '0;
         head_ff     <= 1'b1;
         case (f_cmd)
            pds_pkg::CMD_ADD: begin
               status_ff   <= free_found ? pds_pkg::STS_OK : pds_pkg::STS_FULL;
               slot_out_ff <= free_found ? pds_pkg::SLOT_W'(free_idx) : '0;
            end
            pds_pkg::CMD_REMOVE: begin
               status_ff   <= rm_hit ? pds_pkg::STS_OK : pds_pkg::STS_NOT_FOUND;
               slot_out_ff <= f_slot;
            end
            pds_pkg::CMD_CLEAR: begin
               status_ff   <= pds_pkg::STS_OK;
               slot_out_ff <= '0;
            end
            default: begin
               status_ff   <= pds_pkg::STS_EMPTY;
               slot_out_ff <= '0;
            end
         endcase
      end
      // fire the current candidate
      if (state_ff == pds_pkg::ST_FIRE) begin
         head_ff              <= 1'b0;
         tgt_ff               <= cand_idx_ff;
         done_ff[cand_idx_ff] <= 1'b1;
         per_ff               <= cand_p_ff;
         base_ff              <= base_nx;
         neg_ff               <= diff[TW];
         absd_ff              <= diff_abs[TW-1:0];
         status_ff            <= pds_pkg::STS_OK;
         fired_ff             <= 1'b1;
         slot_out_ff          <= pds_pkg::SLOT_W'(cand_idx_ff);
      end
      // scan: earliest overall and earliest not yet fired
      if (state_ff == pds_pkg::ST_SCAN_INIT) begin
         scan_cnt_ff <= '0;
         all_vld_ff  <= 1'b0;
         cand_vld_ff <= 1'b0;
      end
      if (scan_issue) begin
         scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
         rd_idx_ff   <= scan_cnt_ff[IDX_W-1:0];
      end
      if (rd_pend_ff && valid_ff[rd_idx_ff]) begin
         if (!all_vld_ff || rd_d < all_d_ff) begin
            all_vld_ff <= 1'b1;
            all_d_ff   <= rd_d;
         end
         if (!done_ff[rd_idx_ff] && (!cand_vld_ff || rd_d < cand_d_ff)) begin
            cand_vld_ff <= 1'b1;
            cand_d_ff   <= rd_d;
            cand_p_ff   <= rd_p;
            cand_idx_ff <= rd_idx_ff;
         end
      end
      // result transfer into the output register
      if (emit_go) begin
         nres_ff     <= nres_ff + RW'(1);
         rsp_last_ff <= last_now;
         rsp_data_ff <= {1'b0, all_vld_ff, (all_vld_ff ? all_d_ff : {TW{1'b0}}),
                         status_ff, fired_ff, slot_out_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> valid_ff[$past(tgt_ff)])
      else $error("written slot not marked valid");
   a_fire_has_cand: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pds_pkg::ST_FIRE) |-> cand_vld_ff)
      else $error("fire without a candidate");
   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[4]) |-> (rsp_data_ff[6:5] == pds_pkg::STS_OK))
      else $error("fired result with bad status");
   a_empty_zero_deadline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[70]) |-> (rsp_data_ff[69:7] == '0))
      else $error("deadline shown for empty table");
   a_write_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pds_pkg::ST_WRITE) |-> !div_busy)
      else $error("table write while remainder unit busy");
`endif

endmodule

`default_nettype wire
